FILE: hw/rtl/mcpc_pkg.sv
// mcpc_pkg: shared types, constants and the CRC byte fold for the message
// CRC / pseudo-DES digest core. No dependencies.
`default_nettype none

package mcpc_pkg;

    localparam int unsigned CRC_W           = 16;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned WORD_W          = 32;
    localparam int unsigned DIGEST_W        = 64;
    localparam int unsigned MIX_ROUNDS      = 4;
    localparam int unsigned ROUND_W         = $clog2(MIX_ROUNDS);
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    // APB map: one 32-bit register, index = paddr / 4
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_KEY = 1'b0;

    // one finished message handed from front to back
    typedef struct packed {
        logic [CRC_W-1:0]  crc;
        logic [WORD_W-1:0] seed;
    } mix_job_t;

    // job queue status
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [CRC_W-1:0] crc_fold(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] v;
        v = crc ^ {data, 8'h00};
        for (int i = 0; i < BYTE_W; i++) begin
            if (v[CRC_W-1])
                v = {v[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                v = {v[CRC_W-2:0], 1'b0};
        end
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] mix_c1(input logic [ROUND_W-1:0] r);
        logic [WORD_W-1:0] c;
        case (r)
            2'd0:    c = 32'hcba4e531;
            2'd1:    c = 32'h537158eb;
            2'd2:    c = 32'h145cdc3c;
            default: c = 32'h0d3fdeb2;
        endcase
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] mix_c2(input logic [ROUND_W-1:0] r);
        logic [WORD_W-1:0] c;
        case (r)
            2'd0:    c = 32'h12be4590;
            2'd1:    c = 32'hab54ce58;
            2'd2:    c = 32'h6954c7a6;
            default: c = 32'h15a2ca46;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mcpc_front.sv
// mcpc_front: byte intake, running CRC-16 and job hand-off on the last byte.
// Depends on mcpc_pkg.
`default_nettype none

module mcpc_front
    import mcpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              last_byte,
    input  wire logic [WORD_W-1:0] seed,
    input  wire q_stat_t           q_stat,
    output logic                   full,
    output logic                   q_push,
    output mix_job_t               q_wdata
);

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic [CRC_W-1:0] crc_folded;
    logic             accept;

    assign full       = q_stat.full;
    assign accept     = push && !q_stat.full;
    assign crc_folded = crc_fold(crc_reg, data_byte);

    always_comb
    begin
        crc_next = crc_reg;
        if (accept)
            crc_next = last_byte ? '0 : crc_folded;
    end

    assign q_push       = accept && last_byte;
    assign q_wdata.crc  = crc_folded;
    assign q_wdata.seed = seed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= '0;
        else
            crc_reg <= crc_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mcpc_queue.sv
// mcpc_queue: short FIFO of finished-message jobs between front and back.
// Depends on mcpc_pkg. DEPTH >= 2.
`default_nettype none

module mcpc_queue
    import mcpc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr_en,
    input  wire mix_job_t wr_data,
    input  wire logic     rd_en,
    output mix_job_t      rd_data,
    output q_stat_t       stat
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mix_job_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mcpc_mix.sv
// mcpc_mix: four-round pseudo-DES digest engine plus result register.
// Depends on mcpc_pkg.
`default_nettype none

module mcpc_mix
    import mcpc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire q_stat_t       q_stat,
    input  wire mix_job_t      q_rdata,
    output logic               q_pop,
    input  wire logic          pop,
    output logic               empty,
    output logic [DIGEST_W-1:0] checksum_value
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ADD  = 4'b0100,
        S_HOLD = 4'b1000
    } mix_state_t;

    mix_state_t          state_reg, state_next;
    logic [ROUND_W-1:0]  round_reg, round_next;
    logic [WORD_W-1:0]   l_reg, l_next;
    logic [WORD_W-1:0]   r_reg, r_next;
    logic [WORD_W-1:0]   p_ll_reg, p_hh_reg, p_lh_reg;
    logic [WORD_W-1:0]   p_ll_next, p_hh_next, p_lh_next;
    logic [DIGEST_W-1:0] out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [WORD_W-1:0]   a_word;
    logic [15:0]         a_lo, a_hi;
    logic [WORD_W-1:0]   b_word, rot_word, f_word;
    logic                out_free;

    // multiply step: split the keyed right word, three 16x16 products
    assign a_word    = r_reg ^ mix_c1(round_reg);
    assign a_lo      = a_word[15:0];
    assign a_hi      = a_word[31:16];
    assign p_ll_next = WORD_W'(a_lo) * WORD_W'(a_lo);
    assign p_hh_next = WORD_W'(a_hi) * WORD_W'(a_hi);
    assign p_lh_next = WORD_W'(a_lo) * WORD_W'(a_hi);

    // add step: combine products into the round function
    assign b_word   = p_ll_reg + ~p_hh_reg;
    assign rot_word = {b_word[15:0], b_word[31:16]};
    assign f_word   = (rot_word ^ mix_c2(round_reg)) + p_lh_reg;

    assign out_free       = !out_valid_reg || pop;
    assign q_pop          = (state_reg == S_IDLE) && !q_stat.empty;
    assign empty          = !out_valid_reg;
    assign checksum_value = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    l_next     = WORD_W'(q_rdata.crc);
                    r_next     = q_rdata.seed;
                    round_next = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                l_next     = r_reg;
                r_next     = l_reg ^ f_word;
                round_next = round_reg + 1'b1;
                if (round_reg == ROUND_W'(MIX_ROUNDS - 1))
                    state_next = S_HOLD;
                else
                    state_next = S_MUL;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_next       = {l_reg, r_reg};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg   <= l_next;
        r_reg   <= r_next;
        out_reg <= out_next;
        if (state_reg == S_MUL)
        begin
            p_ll_reg <= p_ll_next;
            p_hh_reg <= p_hh_next;
            p_lh_reg <= p_lh_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/message_crc_psdes_checksum_core.sv
// message_crc_psdes_checksum_core: top level - APB seed register, CRC front,
// job queue and pseudo-DES digest back end. Depends on mcpc_pkg and mcpc_* modules.
//
//  channel  | direction | handshake                 | beat payload
//  ---------+-----------+---------------------------+------------------------------
//  bytes    | in        | push / full               | data_byte[7:0], last_byte
//  digest   | out       | empty / pop               | checksum_value[63:0]
//  config   | in        | APB psel/penable/pready   | seed_key at byte address 0
//
// Byte beats are taken one per cycle while full is low; each CRC-16 fold is registered.
// A last byte pushes {crc, seed} into the job queue (QUEUE_DEPTH entries); full
// rises only while that queue is full, so non-last bytes stall with it too.
// The digest engine, when idle, takes a job once the queue shows it, then runs
// 4 rounds, each a multiply state then an add state, and a hold state that
// hands the result to the output register; it takes no new job until idle.
// A result waiting in the output register stalls only the hold state.
// rst_n clears the CRC, queue pointers, engine state and seed_key.
`default_nettype none

module message_crc_psdes_checksum_core
    import mcpc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // byte channel
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [BYTE_W-1:0]     data_byte,
    input  wire logic                  last_byte,
    // digest channel
    output logic                       empty,
    input  wire logic                  pop,
    output logic [DIGEST_W-1:0]        checksum_value,
    // APB configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [WORD_W-1:0]     pwdata,
    output logic [WORD_W-1:0]          prdata,
    output logic                       pready
);

    logic [WORD_W-1:0]    seed_key_reg;
    logic [WORD_W-1:0]    seed_key_next;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;

    q_stat_t              q_stat;
    logic                 q_push;
    logic                 q_pop;
    mix_job_t             q_wdata;
    mix_job_t             q_rdata;

    // APB: zero-wait, word index from paddr[2]
    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        seed_key_next = seed_key_reg;
        if (cfg_wr && (cfg_idx == REG_SEED_KEY))
            seed_key_next = pwdata;
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_idx == REG_SEED_KEY)
            prdata = seed_key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_key_reg <= '0;
        else
            seed_key_reg <= seed_key_next;
    end

    // front: CRC fold, seed sampled with the last byte
    mcpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .seed      (seed_key_reg),
        .q_stat    (q_stat),
        .full      (full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    mcpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .stat    (q_stat)
    );

    // back: multi-cycle digest and result register
    mcpc_mix u_mix (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .q_rdata        (q_rdata),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .checksum_value (checksum_value)
    );

    // a last-byte beat leaves a job visible in the queue next cycle
    a_job_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && last_byte) |=> !q_stat.empty)
        else $error("last-byte beat did not reach the job queue");

    // back end only takes jobs that exist
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("digest engine popped an empty job queue");

    // queue status is consistent
    a_stat_sane: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !q_stat.empty)
        else $error("job queue reports both full and empty");

endmodule

`default_nettype wire
